[hdl/lmt_pkg.sv]
// shared types, constants and helper function for the lcd mode and line timer
`timescale 1ns / 1ps

package lmt_pkg;

  localparam int CountW = 8;
  localparam int LineW  = 8;
  localparam int AccW   = 13;
  localparam int ModeW  = 2;

  localparam logic [AccW-1:0]  AccMax          = 13'd8191;
  localparam logic [7:0]       OamCycles       = 8'd83;
  localparam logic [7:0]       XferCycles      = 8'd175;
  localparam logic [7:0]       HblankCycles    = 8'd207;
  localparam logic [8:0]       VblankLineCycles = 9'd465;
  localparam logic [AccW-1:0]  FrameCycles     = 13'd4560;
  localparam logic [LineW-1:0] VblankFirstLine = 8'd144;
  localparam logic [LineW-1:0] VblankBase      = 8'd143;
  localparam logic [LineW-1:0] LastLine        = 8'd153;

  // enough shifted subtractions to reduce any accumulator value by the line constants
  localparam int ModSteps = 7;

  typedef enum logic [ModeW-1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lmt_mode_t;

  typedef struct packed {
    lmt_mode_t        mode;
    logic [LineW-1:0] line;
    logic [AccW-1:0]  acc;
  } lmt_state_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [LineW-1:0] line_now;
    logic             vblank_irq;
    logic             draw_line;
    logic             fetch_sprites;
    logic             decode_tiles;
    logic             frame_done;
  } lmt_result_t;

  // remainder by a small constant through shifted compare and subtract
  function automatic logic [AccW-1:0] mod_small(input logic [AccW-1:0] x,
                                                input logic [7:0] d);
    logic [AccW-1:0] r;
    logic [14:0]     sh;
    r  = x;
    sh = '0;
    for (int k = ModSteps - 1; k >= 0; k--) begin
      sh = {7'd0, d} << k;
      if ({2'd0, r} >= sh) begin
        r = r - sh[AccW-1:0];
      end
    end
    return r;
  endfunction

endpackage

[hdl/lmt_if.sv]
// valid/ready channel interfaces for the tick input and the timing result
`timescale 1ns / 1ps

interface lmt_in_if;
  logic                       valid;
  logic                       ready;
  logic [lmt_pkg::CountW-1:0] cycle_count;
  logic                       lcd_on;

  modport source(output valid, output cycle_count, output lcd_on, input ready);
  modport sink(input valid, input cycle_count, input lcd_on, output ready);
endinterface

interface lmt_out_if;
  logic                      valid;
  logic                      ready;
  logic [lmt_pkg::ModeW-1:0] mode;
  logic [lmt_pkg::LineW-1:0] line_now;
  logic                      vblank_irq;
  logic                      draw_line;
  logic                      fetch_sprites;
  logic                      decode_tiles;
  logic                      frame_done;

  modport source(output valid, output mode, output line_now, output vblank_irq,
                 output draw_line, output fetch_sprites, output decode_tiles,
                 output frame_done, input ready);
  modport sink(input valid, input mode, input line_now, input vblank_irq,
               input draw_line, input fetch_sprites, input decode_tiles,
               input frame_done, output ready);
endinterface

[hdl/lmt_step.sv]
// next-state and result logic for one tick of the mode and line timer
`timescale 1ns / 1ps

module lmt_step (
  input  lmt_pkg::lmt_state_t           state_cur,
  input  logic [lmt_pkg::CountW-1:0]    cycle_count,
  input  logic                          lcd_on,
  output lmt_pkg::lmt_state_t           state_nxt,
  output lmt_pkg::lmt_result_t          result
);

  logic [lmt_pkg::AccW:0]    sum;
  logic [lmt_pkg::AccW-1:0]  acc_sat;
  logic [lmt_pkg::LineW-1:0] line_inc;
  logic [lmt_pkg::LineW-1:0] line_ofs;
  logic [16:0]               vb_thr;
  logic                      vb_step;
  logic [lmt_pkg::AccW-1:0]  frame_wrap;

  assign sum      = {1'b0, state_cur.acc} + {{(lmt_pkg::AccW + 1 - lmt_pkg::CountW){1'b0}},
                                             cycle_count};
  assign acc_sat  = sum[lmt_pkg::AccW] ? lmt_pkg::AccMax : sum[lmt_pkg::AccW-1:0];
  assign line_inc = state_cur.line + 8'd1;

  // vblank line step: acc / 465 + 144 > line
  assign line_ofs = state_cur.line - lmt_pkg::VblankBase;
  assign vb_thr   = 17'(line_ofs) * 17'(lmt_pkg::VblankLineCycles);
  assign vb_step  = (state_cur.line < lmt_pkg::VblankFirstLine) || ({4'd0, acc_sat} >= vb_thr);

  assign frame_wrap = (acc_sat >= lmt_pkg::FrameCycles) ? acc_sat - lmt_pkg::FrameCycles
                                                        : acc_sat;

  always_comb begin
    state_nxt            = state_cur;
    result               = '0;
    if (lcd_on) begin
      state_nxt.acc = acc_sat;
      case (state_cur.mode)
        lmt_pkg::MODE_HBLANK: begin
          if (acc_sat > 13'(lmt_pkg::HblankCycles)) begin
            result.draw_line = 1'b1;
            state_nxt.acc    = lmt_pkg::mod_small(acc_sat, lmt_pkg::HblankCycles);
            state_nxt.line   = line_inc;
            if (line_inc == lmt_pkg::VblankFirstLine) begin
              state_nxt.mode    = lmt_pkg::MODE_VBLANK;
              result.vblank_irq = 1'b1;
            end else begin
              state_nxt.mode = lmt_pkg::MODE_OAM;
            end
          end
        end
        lmt_pkg::MODE_VBLANK: begin
          if (vb_step) begin
            state_nxt.line = line_inc;
            if (line_inc > lmt_pkg::LastLine) begin
              state_nxt.acc     = frame_wrap;
              state_nxt.mode    = lmt_pkg::MODE_OAM;
              state_nxt.line    = '0;
              result.frame_done = 1'b1;
            end
          end
        end
        lmt_pkg::MODE_OAM: begin
          if (acc_sat > 13'(lmt_pkg::OamCycles)) begin
            result.fetch_sprites = 1'b1;
            state_nxt.acc        = lmt_pkg::mod_small(acc_sat, lmt_pkg::OamCycles);
            state_nxt.mode       = lmt_pkg::MODE_XFER;
          end
        end
        default: begin
          if (acc_sat > 13'(lmt_pkg::XferCycles)) begin
            result.decode_tiles = 1'b1;
            state_nxt.acc       = lmt_pkg::mod_small(acc_sat, lmt_pkg::XferCycles);
            state_nxt.mode      = lmt_pkg::MODE_HBLANK;
          end
        end
      endcase
    end else begin
      state_nxt.acc  = '0;
      state_nxt.line = '0;
    end
    result.mode     = state_nxt.mode;
    result.line_now = state_nxt.line;
  end

endmodule

[hdl/lcd_mode_line_timer.sv]
// top level of the lcd mode and scanline timer
`timescale 1ns / 1ps

// Takes one tick transaction per clock cycle while in_ch.ready is high and returns one result
// transaction per tick. The mode, line and cycle accumulator update in the cycle the tick is
// accepted; the result sits in an output register and appears in the cycle after acceptance.
// Throughput is one tick per cycle, set by the combinational state update loop; in_ch.ready drops
// only while a result is held in the output register and the sink is not taking it. After reset
// the timer is in V-blank at line 0 with an empty accumulator.

module lcd_mode_line_timer (
  input  logic      clk,
  input  logic      rst_n,
  lmt_in_if.sink    in_ch,
  lmt_out_if.source out_ch
);

  lmt_pkg::lmt_state_t  state_r;
  lmt_pkg::lmt_state_t  state_nxt;
  lmt_pkg::lmt_result_t res_r;
  lmt_pkg::lmt_result_t res_nxt;
  logic                 out_valid_r;
  logic                 in_accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  lmt_step u_step (
    .state_cur   (state_r),
    .cycle_count (in_ch.cycle_count),
    .lcd_on      (in_ch.lcd_on),
    .state_nxt   (state_nxt),
    .result      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode <= lmt_pkg::MODE_VBLANK;
      state_r.line <= '0;
      state_r.acc  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mode          = res_r.mode;
  assign out_ch.line_now      = res_r.line_now;
  assign out_ch.vblank_irq    = res_r.vblank_irq;
  assign out_ch.draw_line     = res_r.draw_line;
  assign out_ch.fetch_sprites = res_r.fetch_sprites;
  assign out_ch.decode_tiles  = res_r.decode_tiles;
  assign out_ch.frame_done    = res_r.frame_done;

`ifndef SYNTHESIS
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.line <= lmt_pkg::LastLine)
    else $error("scanline beyond last line");

  a_lcd_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_ch.lcd_on) |=> (state_r.acc == '0 && state_r.line == '0))
    else $error("lcd off did not clear timing");

  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_done) |->
      (out_ch.line_now == '0 && out_ch.mode == lmt_pkg::MODE_OAM))
    else $error("frame done without return to line 0");

  a_vblank_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.vblank_irq) |->
      (out_ch.line_now == lmt_pkg::VblankFirstLine && out_ch.mode == lmt_pkg::MODE_VBLANK
       && out_ch.draw_line))
    else $error("vblank request outside vblank entry");

  a_one_exit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $onehot0({out_ch.draw_line, out_ch.fetch_sprites,
                               out_ch.decode_tiles, out_ch.frame_done}))
    else $error("more than one mode exit in a tick");
`endif

endmodule
